[rtl/qtl_pkg.sv]
// qtl_pkg: shared types, codes and character constants of the quoted token lexer
// no dependencies; used by the channel interfaces, qtl_lexer and quoted_token_lexer_core

package qtl_pkg;

    // result word kinds
    typedef enum logic [1:0] {
        KIND_BYTE       = 2'd0,
        KIND_TOKEN_END  = 2'd1,
        KIND_SEPARATOR  = 2'd2,
        KIND_STREAM_END = 2'd3
    } kind_t;

    // lexer modes
    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_BARE    = 3'd2,
        MODE_QUOTED  = 3'd3,
        MODE_ESCAPE  = 3'd4,
        MODE_OCTAL   = 3'd5
    } lex_mode_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SKIP_SEPARATORS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPAT_ESCAPES  = 1'b1;

    // most result words one input word can cause
    localparam logic [1:0] RES_MAX = 2'd3;
    localparam logic [1:0] OCTAL_DIGITS_MAX = 2'd3;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    // upper five bits shared by '0' .. '7'
    localparam logic [4:0] OCTAL_DIGIT_HI = 5'b00110;

    typedef struct packed {
        logic skip_separators;
        logic compat_escapes;
    } cfg_t;

    typedef struct packed {
        lex_mode_t   mode;
        logic        quote_dq;
        logic [8:0]  octal_value;
        logic [1:0]  octal_digits;
    } lex_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } result_t;

    // group of result words caused by one input word
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     res;
    } bundle_t;

    // single-letter escapes, anything else maps to itself
    function automatic logic [7:0] esc_map(logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h74:   r = 8'h09;  // t
            8'h6E:   r = 8'h0A;  // n
            8'h72:   r = 8'h0D;  // r
            8'h62:   r = 8'h08;  // b
            8'h66:   r = 8'h0C;  // f
            8'h76:   r = 8'h0B;  // v
            8'h61:   r = 8'h07;  // a
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

[rtl/qtl_text_if.sv]
// qtl_text_if: input channel carrying one raw text word per handshake
// depends on qtl_pkg

interface qtl_text_if;
    import qtl_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;
    modport source (output valid, in_byte, stream_end, input ready);
    modport sink   (input valid, in_byte, stream_end, output ready);
endinterface

[rtl/qtl_token_if.sv]
// qtl_token_if: output channel carrying one lexer result word per handshake
// depends on qtl_pkg

interface qtl_token_if;
    import qtl_pkg::*;
    logic       valid;
    logic       ready;
    kind_t      kind;
    logic [7:0] out_byte;
    logic       last;
    modport source (output valid, kind, out_byte, last, input ready);
    modport sink   (input valid, kind, out_byte, last, output ready);
endinterface

[rtl/qtl_cfg_if.sv]
// qtl_cfg_if: configuration write channel, register index and write data
// depends on qtl_pkg

interface qtl_cfg_if;
    import qtl_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic                   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/quoted_token_lexer_core.sv]
// quoted_token_lexer_core: byte-serial tokenizer with quoting, escapes and comments.
// One raw text word enters on the text channel per cycle while the queue has room. Its
// lexer step is done in the same cycle and the one to three result words it may cause
// are written as one group into a two-group result queue; the token channel hands them
// out one word per cycle while the sink is ready, marking the final word of each group
// with last. The sustained rate is thus one input word per cycle as long as each word
// gives at most one result and the sink is ready; a word that gives two or three
// results keeps the token port busy while its words go out, which then sets the rate.
// Spaces and tabs are skipped, '#' opens a comment to end of line, CR, LF and ';' give
// separator words unless skip_separators is set, and quoted tokens decode backslash
// escapes (literal backslashes kept, except before a double quote, when compat_escapes
// is set). Configuration writes are always taken and should only be issued while the
// block is idle.
// depends on qtl_pkg, qtl_text_if, qtl_token_if, qtl_cfg_if and qtl_lexer

module quoted_token_lexer_core (
    input  logic        clk,
    input  logic        rst_n,
    qtl_text_if.sink    text,
    qtl_token_if.source token,
    qtl_cfg_if.sink     cfg
);
    import qtl_pkg::*;

    // configuration registers
    cfg_t       cfg_reg;

    // lexer step output for the word on the text channel
    bundle_t    step_bundle;
    logic       in_fire;
    logic       push;

    // result group queue, two entries
    bundle_t    q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    // word position inside the head group
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    bundle_t    head;
    logic       out_fire;
    logic       head_last;
    logic       pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_SKIP_SEPARATORS: cfg_reg.skip_separators <= cfg.data;
                REG_COMPAT_ESCAPES:  cfg_reg.compat_escapes  <= cfg.data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input side: room in the queue means the step result has a place to go
    assign text.ready = (cnt_reg != 2'd2);
    assign in_fire    = text.valid && text.ready;

    qtl_lexer u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_fire),
        .in_byte    (text.in_byte),
        .stream_end (text.stream_end),
        .cfg        (cfg_reg),
        .bundle     (step_bundle)
    );

    // words that cause no result leave nothing in the queue
    assign push = in_fire && (step_bundle.count != 2'd0);

    // output side: serialize the head group one word at a time
    assign head        = q_reg[rd_ptr_reg];
    assign token.valid = (cnt_reg != 2'd0);
    assign token.kind  = head.res[idx_reg].kind;
    assign token.out_byte = head.res[idx_reg].data;
    assign head_last   = (idx_reg == head.count - 2'd1);
    assign token.last  = head_last;
    assign out_fire    = token.valid && token.ready;
    assign pop         = out_fire && head_last;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
        if (pop)
            idx_next = 2'd0;
        else if (out_fire)
            idx_next = idx_reg + 2'd1;
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= step_bundle;
    end

`ifndef ASSERT_OFF
    // queue never holds more than two groups
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue overflow");

    // word position stays inside the head group
    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        token.valid |-> (idx_reg < head.count))
        else $error("word position beyond head group");

    // a stream end word always closes its group
    a_stream_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (token.valid && token.kind == KIND_STREAM_END) |-> token.last)
        else $error("stream end word not last of its group");

    // an accepted word with a full queue is impossible
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> (cnt_reg == 2'd2))
        else $error("queue changed while full and not drained");
`endif

endmodule

[rtl/qtl_lexer.sv]
// qtl_lexer: lexer state registers and the combinational step logic
// depends on qtl_pkg

module qtl_lexer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       in_byte,
    input  logic             stream_end,
    input  qtl_pkg::cfg_t    cfg,
    output qtl_pkg::bundle_t bundle
);
    import qtl_pkg::*;

    typedef struct packed {
        lex_state_t st;
        bundle_t    b;
    } step_t;

    lex_state_t state_reg;
    lex_state_t state_next;
    step_t      s;

    function automatic step_t add(step_t x, kind_t k, logic [7:0] d);
        step_t r;
        r = x;
        if (x.b.count < RES_MAX)
        begin
            r.b.res[x.b.count].kind = k;
            r.b.res[x.b.count].data = d;
            r.b.count = x.b.count + 2'd1;
        end
        return r;
    endfunction

    function automatic logic is_octal(logic [7:0] c);
        return c[7:3] == OCTAL_DIGIT_HI;
    endfunction

    function automatic step_t between_fn(step_t x, logic [7:0] c, cfg_t g);
        step_t r;
        r = x;
        if (c == CH_SPACE || c == CH_TAB)
        begin
            r = x;
        end
        else if (c == CH_HASH)
        begin
            r.st.mode = MODE_COMMENT;
        end
        else if (c == CH_CR || c == CH_LF || c == CH_SEMI)
        begin
            if (!g.skip_separators)
                r = add(r, KIND_SEPARATOR, 8'h00);
        end
        else if (c == CH_SQUOTE || c == CH_DQUOTE)
        begin
            r.st.quote_dq = (c == CH_DQUOTE);
            r.st.mode     = MODE_QUOTED;
        end
        else
        begin
            r = add(r, KIND_BYTE, c);
            r.st.mode = MODE_BARE;
        end
        return r;
    endfunction

    function automatic step_t quoted_fn(step_t x, logic [7:0] c);
        step_t r;
        r = x;
        if (c == (x.st.quote_dq ? CH_DQUOTE : CH_SQUOTE))
        begin
            r = add(r, KIND_TOKEN_END, 8'h00);
            r.st.mode = MODE_BETWEEN;
        end
        else if (c == CH_BSLASH)
        begin
            r.st.mode = MODE_ESCAPE;
        end
        else
        begin
            r = add(r, KIND_BYTE, c);
        end
        return r;
    endfunction

    function automatic step_t escape_fn(step_t x, logic [7:0] c, cfg_t g);
        step_t r;
        r = x;
        if (g.compat_escapes && c != CH_DQUOTE)
        begin
            r = add(r, KIND_BYTE, CH_BSLASH);
            r = add(r, KIND_BYTE, c);
            r.st.mode = MODE_QUOTED;
        end
        else if (is_octal(c))
        begin
            r.st.octal_value  = {6'd0, c[2:0]};
            r.st.octal_digits = 2'd1;
            r.st.mode         = MODE_OCTAL;
        end
        else
        begin
            r = add(r, KIND_BYTE, esc_map(c));
            r.st.mode = MODE_QUOTED;
        end
        return r;
    endfunction

    function automatic step_t octal_fn(step_t x, logic [7:0] c);
        step_t      r;
        logic [8:0] v;
        logic [1:0] d;
        r = x;
        v = {x.st.octal_value[5:0], c[2:0]};
        d = x.st.octal_digits + 2'd1;
        if (is_octal(c) && x.st.octal_digits < OCTAL_DIGITS_MAX)
        begin
            if (d == OCTAL_DIGITS_MAX)
            begin
                r = add(r, KIND_BYTE, v[7:0]);
                r.st.octal_value  = '0;
                r.st.octal_digits = '0;
                r.st.mode         = MODE_QUOTED;
            end
            else
            begin
                r.st.octal_value  = v;
                r.st.octal_digits = d;
            end
        end
        else
        begin
            // escape ended early by a non-digit, which is then handled as in quoted mode
            r = add(r, KIND_BYTE, x.st.octal_value[7:0]);
            r.st.octal_value  = '0;
            r.st.octal_digits = '0;
            r.st.mode         = MODE_QUOTED;
            r = quoted_fn(r, c);
        end
        return r;
    endfunction

    function automatic step_t end_fn(step_t x, cfg_t g);
        step_t r;
        r = x;
        unique case (x.st.mode)
            MODE_BARE, MODE_QUOTED:
            begin
                r = add(r, KIND_TOKEN_END, 8'h00);
            end
            MODE_ESCAPE:
            begin
                if (g.compat_escapes)
                    r = add(r, KIND_BYTE, CH_BSLASH);
                r = add(r, KIND_TOKEN_END, 8'h00);
            end
            MODE_OCTAL:
            begin
                r = add(r, KIND_BYTE, x.st.octal_value[7:0]);
                r = add(r, KIND_TOKEN_END, 8'h00);
            end
            default:
            begin
                r = x;
            end
        endcase
        r = add(r, KIND_STREAM_END, 8'h00);
        r.st.mode         = MODE_BETWEEN;
        r.st.quote_dq     = 1'b0;
        r.st.octal_value  = '0;
        r.st.octal_digits = '0;
        return r;
    endfunction

    always_comb
    begin
        s.st = state_reg;
        s.b  = '0;
        if (stream_end)
        begin
            s = end_fn(s, cfg);
        end
        else
        begin
            unique case (state_reg.mode)
                MODE_COMMENT:
                begin
                    if (in_byte == CH_CR || in_byte == CH_LF)
                    begin
                        s.st.mode = MODE_BETWEEN;
                        if (!cfg.skip_separators)
                            s = add(s, KIND_SEPARATOR, 8'h00);
                    end
                end
                MODE_BARE:
                begin
                    if (in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_HASH
                        || in_byte == CH_CR || in_byte == CH_LF || in_byte == CH_SEMI)
                    begin
                        s = add(s, KIND_TOKEN_END, 8'h00);
                        s.st.mode = MODE_BETWEEN;
                        s = between_fn(s, in_byte, cfg);
                    end
                    else
                    begin
                        s = add(s, KIND_BYTE, in_byte);
                    end
                end
                MODE_QUOTED: s = quoted_fn(s, in_byte);
                MODE_ESCAPE: s = escape_fn(s, in_byte, cfg);
                MODE_OCTAL:  s = octal_fn(s, in_byte);
                default:
                begin
                    s.st.mode = MODE_BETWEEN;
                    s = between_fn(s, in_byte, cfg);
                end
            endcase
        end
    end

    assign state_next = fire ? s.st : state_reg;
    assign bundle     = s.b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode         <= MODE_BETWEEN;
            state_reg.quote_dq     <= 1'b0;
            state_reg.octal_value  <= '0;
            state_reg.octal_digits <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
